FILE: hw/rtl/wsd_pkg.sv
// wsd_pkg: shared types and codes of the websocket frame deframer
// used by websocket_frame_deframer and wsd_out_fifo; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package wsd_pkg;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       local_close_sent;
    } in_item_t;

    typedef struct packed {
        logic [7:0] payload_byte;
        logic       payload_valid;
        logic [3:0] message_opcode;
        logic       message_end;
        logic [2:0] end_action;
        logic [2:0] error_code;
    } out_item_t;

    // apb register map
    localparam int unsigned PADDR_W = 3;
    localparam int unsigned PDATA_W = 32;
    localparam logic        REG_MAX_FRAGMENTS = 1'b0;  // paddr[2] word select

    localparam logic [6:0] MAX_FRAGMENTS_RESET = 7'd64;

    // parse phases
    localparam logic [2:0] PH_HDR  = 3'd0;
    localparam logic [2:0] PH_LEN  = 3'd1;
    localparam logic [2:0] PH_EXT  = 3'd2;
    localparam logic [2:0] PH_PAY  = 3'd3;
    localparam logic [2:0] PH_HALT = 3'd4;

    // frame opcodes
    localparam logic [3:0] OP_TEXT   = 4'h1;
    localparam logic [3:0] OP_BINARY = 4'h2;
    localparam logic [3:0] OP_CLOSE  = 4'h8;
    localparam logic [3:0] OP_PING   = 4'h9;
    localparam logic [3:0] OP_PONG   = 4'hA;

    // seven-bit length codes that announce an extended length
    localparam logic [6:0] LEN_EXT16 = 7'd126;
    localparam logic [6:0] LEN_EXT64 = 7'd127;

    // extended length byte counts, stored minus one
    localparam logic [2:0] EXT16_LEFT = 3'd1;
    localparam logic [2:0] EXT64_LEFT = 3'd7;

    // end actions
    localparam logic [2:0] ACT_NONE    = 3'd0;
    localparam logic [2:0] ACT_DELIVER = 3'd1;
    localparam logic [2:0] ACT_PONG    = 3'd2;
    localparam logic [2:0] ACT_CLOSE   = 3'd3;
    localparam logic [2:0] ACT_ABORT   = 3'd4;

    // error codes
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_RSV     = 3'd1;
    localparam logic [2:0] ERR_MASKED  = 3'd2;
    localparam logic [2:0] ERR_OPCODE  = 3'd3;
    localparam logic [2:0] ERR_FRAGS   = 3'd4;

endpackage

`default_nettype wire

FILE: hw/rtl/wsd_out_fifo.sv
// wsd_out_fifo: two-entry result queue between the parse stage and the output
// depends on wsd_pkg for the result item type
`timescale 1ns / 1ps
`default_nettype none

module wsd_out_fifo (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire wsd_pkg::out_item_t push_data,
    output logic                   ready,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output wsd_pkg::out_item_t     out_data
);

    wsd_pkg::out_item_t mem_reg [2];
    logic               wr_ptr_reg;
    logic               wr_ptr_next;
    logic               rd_ptr_reg;
    logic               rd_ptr_next;
    logic [1:0]         count_reg;
    logic [1:0]         count_next;
    logic               pop;
    logic               do_push;

    assign ready     = (count_reg != 2'd2);
    assign out_valid = (count_reg != 2'd0);
    assign out_data  = mem_reg[rd_ptr_reg];
    assign pop       = out_valid && !out_stall;
    assign do_push   = push && ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg;
        if (do_push && !pop)
        begin
            count_next = count_reg + 2'd1;
        end
        else if (pop && !do_push)
        begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/websocket_frame_deframer.sv
// websocket_frame_deframer: byte-wide websocket frame parser, top level
// depends on wsd_pkg and wsd_out_fifo
//
//   channel   direction   handshake               payload
//   in        sink        in_valid / in_stall     in_data  (wsd_pkg::in_item_t)
//   out       source      out_valid / out_stall   out_data (wsd_pkg::out_item_t)
//   apb       slave       psel / penable / pready register max_fragments
//
// one byte per cycle sustained while the result queue is not full; a byte's
// result passes through the input register, where the parse state updates,
// then through the two-entry result queue. in_stall rises only while the queue
// is full and the input register holds a byte. reset clears the parse state,
// empties the queue and sets max_fragments to 64. bytes that give no result push nothing.
`timescale 1ns / 1ps
`default_nettype none

module websocket_frame_deframer (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_stall,
    input  wire wsd_pkg::in_item_t           in_data,
    output logic                             out_valid,
    input  wire logic                        out_stall,
    output wsd_pkg::out_item_t               out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [wsd_pkg::PADDR_W-1:0] paddr,
    input  wire logic [wsd_pkg::PDATA_W-1:0] pwdata,
    output logic [wsd_pkg::PDATA_W-1:0]      prdata,
    output logic                             pready
);

    // configuration
    logic [6:0] max_frag_reg;
    logic       cfg_write;

    // input register
    logic              s_valid_reg;
    wsd_pkg::in_item_t s_item_reg;
    logic              in_accept;
    logic              s_go;
    logic              fifo_ready;

    // parse state
    logic [2:0]  phase_reg;
    logic [2:0]  phase_next;
    logic [2:0]  ext_left_reg;
    logic [2:0]  ext_left_next;
    logic [63:0] pay_left_reg;
    logic [63:0] pay_left_next;
    logic [6:0]  frag_count_reg;
    logic [6:0]  frag_count_next;
    logic [3:0]  first_op_reg;
    logic [3:0]  first_op_next;
    logic        fin_reg;
    logic        fin_next;

    // step results
    logic               emit;
    wsd_pkg::out_item_t res;
    logic               frame_done;
    logic               done_valid;
    logic [7:0]         b;
    logic [63:0]        ext_shifted;
    logic [6:0]         frag_inc;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                       && (paddr[2] == wsd_pkg::REG_MAX_FRAGMENTS);
    assign prdata    = (paddr[2] == wsd_pkg::REG_MAX_FRAGMENTS)
                       ? {{(wsd_pkg::PDATA_W-7){1'b0}}, max_frag_reg}
                       : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_frag_reg <= wsd_pkg::MAX_FRAGMENTS_RESET;
        end
        else if (cfg_write)
        begin
            max_frag_reg <= pwdata[6:0];
        end
    end

    assign s_go      = s_valid_reg && fifo_ready;
    assign in_stall  = s_valid_reg && !fifo_ready;
    assign in_accept = in_valid && !in_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_valid_reg <= 1'b0;
        end
        else if (in_accept)
        begin
            s_valid_reg <= 1'b1;
        end
        else if (s_go)
        begin
            s_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            s_item_reg <= in_data;
        end
    end

    assign b           = s_item_reg.rx_byte;
    assign ext_shifted = {pay_left_reg[55:0], b};
    assign frag_inc    = frag_count_reg + 7'd1;

    always_comb
    begin
        phase_next      = phase_reg;
        ext_left_next   = ext_left_reg;
        pay_left_next   = pay_left_reg;
        frag_count_next = frag_count_reg;
        first_op_next   = first_op_reg;
        fin_next        = fin_reg;
        emit            = 1'b0;
        frame_done      = 1'b0;
        done_valid      = 1'b0;
        res.payload_byte   = 8'd0;
        res.payload_valid  = 1'b0;
        res.message_end    = 1'b0;
        res.end_action     = wsd_pkg::ACT_NONE;
        res.error_code     = wsd_pkg::ERR_NONE;

        unique case (phase_reg)
            wsd_pkg::PH_HDR:
            begin
                if (frag_count_reg == 7'd0)
                begin
                    first_op_next = b[3:0];
                end
                fin_next = b[7];
                if (b[6:4] != 3'd0)
                begin
                    phase_next      = wsd_pkg::PH_HALT;
                    emit            = 1'b1;
                    res.message_end = 1'b1;
                    res.error_code  = wsd_pkg::ERR_RSV;
                end
                else
                begin
                    phase_next = wsd_pkg::PH_LEN;
                end
            end
            wsd_pkg::PH_LEN:
            begin
                if (b[7])
                begin
                    phase_next      = wsd_pkg::PH_HALT;
                    emit            = 1'b1;
                    res.message_end = 1'b1;
                    res.error_code  = wsd_pkg::ERR_MASKED;
                end
                else
                begin
                    pay_left_next = {57'd0, b[6:0]};
                    if (b[6:0] == wsd_pkg::LEN_EXT16 || b[6:0] == wsd_pkg::LEN_EXT64)
                    begin
                        pay_left_next = 64'd0;
                        ext_left_next = (b[6:0] == wsd_pkg::LEN_EXT16)
                                        ? wsd_pkg::EXT16_LEFT : wsd_pkg::EXT64_LEFT;
                        phase_next    = wsd_pkg::PH_EXT;
                    end
                    else if (b[6:0] == 7'd0)
                    begin
                        frame_done = 1'b1;
                    end
                    else
                    begin
                        phase_next = wsd_pkg::PH_PAY;
                    end
                end
            end
            wsd_pkg::PH_EXT:
            begin
                pay_left_next = ext_shifted;
                if (ext_left_reg != 3'd0)
                begin
                    ext_left_next = ext_left_reg - 3'd1;
                end
                else if (ext_shifted == 64'd0)
                begin
                    frame_done = 1'b1;
                end
                else
                begin
                    phase_next = wsd_pkg::PH_PAY;
                end
            end
            wsd_pkg::PH_PAY:
            begin
                pay_left_next = pay_left_reg - 64'd1;
                if (pay_left_reg <= 64'd1)
                begin
                    frame_done = 1'b1;
                    done_valid = 1'b1;
                end
                else
                begin
                    emit              = 1'b1;
                    res.payload_byte  = b;
                    res.payload_valid = 1'b1;
                end
            end
            default:
            begin
                phase_next = wsd_pkg::PH_HALT;
            end
        endcase

        // end of a frame: fragment bookkeeping and the end report
        if (frame_done)
        begin
            phase_next    = wsd_pkg::PH_HDR;
            pay_left_next = 64'd0;
            ext_left_next = 3'd0;
            if (done_valid)
            begin
                res.payload_byte  = b;
                res.payload_valid = 1'b1;
            end
            if (!fin_reg)
            begin
                frag_count_next = frag_inc;
                if (frag_inc >= max_frag_reg)
                begin
                    phase_next        = wsd_pkg::PH_HALT;
                    emit              = 1'b1;
                    res.message_end   = 1'b1;
                    res.error_code    = wsd_pkg::ERR_FRAGS;
                end
                else
                begin
                    emit = done_valid;
                end
            end
            else
            begin
                frag_count_next = 7'd0;
                emit            = 1'b1;
                res.message_end = 1'b1;
                case (first_op_reg) inside
                    wsd_pkg::OP_TEXT, wsd_pkg::OP_BINARY, wsd_pkg::OP_PONG:
                    begin
                        res.end_action = wsd_pkg::ACT_DELIVER;
                    end
                    wsd_pkg::OP_PING:
                    begin
                        res.end_action = wsd_pkg::ACT_PONG;
                    end
                    wsd_pkg::OP_CLOSE:
                    begin
                        phase_next     = wsd_pkg::PH_HALT;
                        res.end_action = s_item_reg.local_close_sent
                                         ? wsd_pkg::ACT_ABORT : wsd_pkg::ACT_CLOSE;
                    end
                    default:
                    begin
                        phase_next     = wsd_pkg::PH_HALT;
                        res.error_code = wsd_pkg::ERR_OPCODE;
                    end
                endcase
            end
        end

        res.message_opcode = first_op_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg      <= wsd_pkg::PH_HDR;
            ext_left_reg   <= 3'd0;
            pay_left_reg   <= 64'd0;
            frag_count_reg <= 7'd0;
            first_op_reg   <= 4'd0;
            fin_reg        <= 1'b0;
        end
        else if (s_go)
        begin
            phase_reg      <= phase_next;
            ext_left_reg   <= ext_left_next;
            pay_left_reg   <= pay_left_next;
            frag_count_reg <= frag_count_next;
            first_op_reg   <= first_op_next;
            fin_reg        <= fin_next;
        end
    end

    wsd_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (s_go && emit),
        .push_data (res),
        .ready     (fifo_ready),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

`ifndef SYNTHESIS
    // once halted the parser stays halted
    a_halt_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        phase_reg == wsd_pkg::PH_HALT |=> phase_reg == wsd_pkg::PH_HALT)
        else $error("parser left the halted phase");

    // an error always closes the message and carries no action
    a_error_ends: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.error_code != wsd_pkg::ERR_NONE
        |-> out_data.message_end && out_data.end_action == wsd_pkg::ACT_NONE)
        else $error("error result without message end or with an action");

    // results in the middle of a message report nothing and carry a byte
    a_mid_message: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.message_end
        |-> out_data.payload_valid && out_data.end_action == wsd_pkg::ACT_NONE
            && out_data.error_code == wsd_pkg::ERR_NONE)
        else $error("mid-message result without payload or with a report");

    // an empty byte lane is zero
    a_empty_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_data.payload_valid |-> out_data.payload_byte == 8'd0)
        else $error("payload byte not zero on a result without payload");
`endif

endmodule

`default_nettype wire
